FILE: rtl/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the .Z stream decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // widest code the decoder accepts from a header
  localparam int MAX_BITS    = 12;
  localparam int TBL_AW      = MAX_BITS;
  localparam int TBL_DEPTH   = 1 << MAX_BITS;
  localparam int FE_W        = MAX_BITS + 1;
  localparam int BUF_W       = 24;

  localparam logic [4:0]        START_WIDTH = 5'd9;
  localparam logic [TBL_AW-1:0] CODE_CLEAR  = TBL_AW'(256);
  localparam logic [FE_W-1:0]   FREE_BLOCK  = FE_W'(257);
  localparam logic [FE_W-1:0]   FREE_PLAIN  = FE_W'(256);
  localparam logic [FE_W-1:0]   STACK_LAST  = FE_W'(TBL_DEPTH - 1);
  localparam logic [7:0]        HDR_A       = 8'h1F;
  localparam logic [7:0]        HDR_B       = 8'h9D;
  localparam logic [4:0]        BUF_ROOM    = 5'd16;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_PULL   = 2'd1,
    CMD_END    = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GIVEN   = 3'd0,
    ST_NEED    = 3'd1,
    ST_END     = 3'd2,
    ST_TAKEN   = 3'd3,
    ST_REFUSED = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    M_HEADER  = 3'd0,
    M_PASS    = 3'd1,
    M_FIRST   = 3'd2,
    M_DECODE  = 3'd3,
    M_CLEARED = 3'd4,
    M_EMIT    = 3'd5,
    M_DONE    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_EXEC  = 3'd1,
    S_EVAL  = 3'd2,
    S_WDATA = 3'd3,
    S_FIN   = 3'd4,
    S_POP   = 3'd5,
    S_OUT   = 3'd6
  } state_t;

  // dictionary port: one write, one read per cycle
  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [TBL_AW-1:0] wpfx;
    logic [7:0]        wsfx;
    logic [TBL_AW-1:0] raddr;
  } dict_req_t;

  // string stack port
  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [TBL_AW-1:0] raddr;
  } stk_req_t;

endpackage

FILE: rtl/lzwd_dict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_dict
// Prefix and suffix tables, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lzwd_dict (
  input  logic                       clk,
  input  lzwd_pkg::dict_req_t        req,
  output logic [lzwd_pkg::TBL_AW-1:0] pfx_rd,
  output logic [7:0]                 sfx_rd
);
  import lzwd_pkg::*;

  logic [TBL_AW-1:0] pfx_mem [TBL_DEPTH];
  logic [7:0]        sfx_mem [TBL_DEPTH];

  // table write
  always_ff @(posedge clk) begin
    if (req.we) begin
      pfx_mem[req.waddr] <= req.wpfx;
      sfx_mem[req.waddr] <= req.wsfx;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    pfx_rd <= pfx_mem[req.raddr];
    sfx_rd <= sfx_mem[req.raddr];
  end

endmodule

FILE: rtl/lzwd_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_stack
// String stack memory holding one decoded string in reverse order.
// ----------------------------------------------------------------------------
module lzwd_stack (
  input  logic               clk,
  input  lzwd_pkg::stk_req_t req,
  output logic [7:0]         rdata
);
  import lzwd_pkg::*;

  logic [7:0] mem [TBL_DEPTH];

  // push write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered pop read
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

FILE: rtl/lzw_compress_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_compress_stream_decoder
// Push/pull decoder for .Z streams with header check and pass-through.
// ----------------------------------------------------------------------------
// flow: push, end and pass-through pulls go from S_EXEC to S_OUT; other pulls
//   pass through S_EVAL; a decoded code walks its chain in S_WDATA over the
//   registered dictionary read, then S_FIN stacks the first byte and adds the
//   entry; a stack pop goes through S_POP; a clear code takes another S_EVAL
// throughput: one beat at a time, next beat taken once the result is queued
// reset: synchronous active-low rst_n clears control state; memories are not
module lzw_compress_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [1:0] in_tuser,   // [1:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser   // [2:0] status
);
  import lzwd_pkg::*;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [BUF_W-1:0]   buf_r, buf_nxt;
  logic [4:0]         bcnt_r, bcnt_nxt;
  logic [4:0]         grp_r, grp_nxt;
  logic               skip_r, skip_nxt;
  logic [4:0]         cw_r, cw_nxt;
  logic [FE_W-1:0]    free_r, free_nxt;
  logic [TBL_AW-1:0]  prev_r, prev_nxt;
  logic [7:0]         fc_r, fc_nxt;
  logic [FE_W-1:0]    depth_r, depth_nxt;
  logic [1:0]         hcnt_r, hcnt_nxt;
  logic               block_r, block_nxt;
  logic [4:0]         maxb_r, maxb_nxt;
  logic               ended_r, ended_nxt;
  logic [1:0]         cmd_r;
  logic [7:0]         byte_r;
  logic [TBL_AW-1:0]  inc_r, inc_nxt;
  logic [7:0]         res_byte_r, res_byte_nxt;
  stat_t              res_stat_r, res_stat_nxt;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic [2:0]         out_stat_r;

  dict_req_t          dict_req;
  stk_req_t           stk_req;
  logic [TBL_AW-1:0]  pfx_rd;
  logic [7:0]         sfx_rd;
  logic [7:0]         stk_rd;

  lzwd_dict u_dict (
    .clk    (clk),
    .req    (dict_req),
    .pfx_rd (pfx_rd),
    .sfx_rd (sfx_rd)
  );

  lzwd_stack u_stack (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rd)
  );

  // code extraction from the bit buffer
  logic [BUF_W-1:0]  code_full;
  logic [TBL_AW-1:0] code;
  logic [BUF_W-1:0]  buf_shift;
  logic              have_code;
  logic              is_clear;
  logic              code_ge_free;
  logic [TBL_AW-1:0] walk_start;
  logic              walk_needed;
  logic              wd_room;
  logic              wd_cont;
  logic              out_free;

  assign code_full    = buf_r & ((BUF_W'(1) << cw_r) - BUF_W'(1));
  assign code         = code_full[TBL_AW-1:0];
  assign buf_shift    = buf_r >> cw_r;
  assign have_code    = bcnt_r >= cw_r;
  assign is_clear     = (mode_r == M_DECODE) && (code == CODE_CLEAR) && block_r;
  assign code_ge_free = {1'b0, code} >= free_r;
  assign walk_start   = code_ge_free ? prev_r : code;
  assign walk_needed  = walk_start[TBL_AW-1:8] != '0;
  assign wd_room      = depth_r < STACK_LAST;
  assign wd_cont      = wd_room && (pfx_rd[TBL_AW-1:8] != '0);
  assign out_free     = !out_valid_r || out_tready;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_stat_r;

  // table growth limit after an entry is added
  logic [FE_W-1:0] top;
  logic [FE_W-1:0] free_inc;
  logic [FE_W:0]   limit;
  logic            can_add;

  assign top      = FE_W'(1) << maxb_r;
  assign can_add  = free_r < top;
  assign free_inc = can_add ? free_r + FE_W'(1) : free_r;
  assign limit    = (cw_r == maxb_r) ? {1'b0, top}
                                     : ((FE_W + 1)'(1) << cw_r) - (FE_W + 1)'(1);

  // byte append for push
  logic [31:0] app_word;
  assign app_word = {8'h00, buf_r} | ({24'h0, byte_r} << bcnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r == CMD_PULL && mode_r != M_HEADER && mode_r != M_PASS) begin
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EVAL: begin
        if (mode_r == M_EMIT) begin
          state_nxt = S_POP;
        end else if (mode_r == M_DONE || !have_code || mode_r == M_FIRST) begin
          state_nxt = S_OUT;
        end else if (is_clear) begin
          state_nxt = S_EVAL;
        end else if (walk_needed) begin
          state_nxt = S_WDATA;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WDATA: begin
        if (!wd_cont) state_nxt = S_FIN;
      end
      S_FIN:   state_nxt = S_EVAL;
      S_POP:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_nxt     = mode_r;
    buf_nxt      = buf_r;
    bcnt_nxt     = bcnt_r;
    grp_nxt      = grp_r;
    skip_nxt     = skip_r;
    cw_nxt       = cw_r;
    free_nxt     = free_r;
    prev_nxt     = prev_r;
    fc_nxt       = fc_r;
    depth_nxt    = depth_r;
    hcnt_nxt     = hcnt_r;
    block_nxt    = block_r;
    maxb_nxt     = maxb_r;
    ended_nxt    = ended_r;
    inc_nxt      = inc_r;
    res_byte_nxt = res_byte_r;
    res_stat_nxt = res_stat_r;
    dict_req     = '0;
    stk_req      = '0;
    case (state_r)
      S_EXEC: begin
        res_byte_nxt = 8'h00;
        case (cmd_r)
          CMD_PUSH: begin
            res_stat_nxt = ST_TAKEN;
            if (ended_r) begin
              res_stat_nxt = ST_REFUSED;
            end else if (mode_r == M_HEADER) begin
              buf_nxt  = app_word[BUF_W-1:0];
              bcnt_nxt = bcnt_r + 5'd8;
              hcnt_nxt = hcnt_r + 2'd1;
              // third byte completes the header
              if (hcnt_r == 2'd2) begin
                if (buf_r[7:0] != HDR_A || buf_r[15:8] != HDR_B ||
                    byte_r[4:0] > 5'(MAX_BITS)) begin
                  mode_nxt = M_PASS;
                end else begin
                  maxb_nxt  = byte_r[4:0];
                  block_nxt = byte_r[7];
                  buf_nxt   = '0;
                  bcnt_nxt  = '0;
                  grp_nxt   = '0;
                  skip_nxt  = 1'b0;
                  cw_nxt    = START_WIDTH;
                  free_nxt  = byte_r[7] ? FREE_BLOCK : FREE_PLAIN;
                  mode_nxt  = M_FIRST;
                end
              end
            end else if (mode_r == M_PASS) begin
              if (bcnt_r > BUF_ROOM) begin
                res_stat_nxt = ST_REFUSED;
              end else begin
                buf_nxt  = app_word[BUF_W-1:0];
                bcnt_nxt = bcnt_r + 5'd8;
              end
            end else if (skip_r) begin
              // rest of a dropped group
              grp_nxt = grp_r - 5'd1;
              if (grp_r == 5'd1) skip_nxt = 1'b0;
            end else if (grp_r == '0 && bcnt_r != '0) begin
              res_stat_nxt = ST_REFUSED;
            end else if (bcnt_r > BUF_ROOM) begin
              res_stat_nxt = ST_REFUSED;
            end else begin
              buf_nxt  = app_word[BUF_W-1:0];
              bcnt_nxt = bcnt_r + 5'd8;
              grp_nxt  = ((grp_r == '0) ? cw_r : grp_r) - 5'd1;
            end
          end
          CMD_END: begin
            ended_nxt    = 1'b1;
            res_stat_nxt = ST_TAKEN;
            if (mode_r == M_HEADER) mode_nxt = M_PASS;
          end
          CMD_PULL: begin
            if (mode_r == M_HEADER) begin
              res_stat_nxt = ST_NEED;
            end else if (mode_r == M_PASS) begin
              if (bcnt_r >= 5'd8) begin
                res_byte_nxt = buf_r[7:0];
                res_stat_nxt = ST_GIVEN;
                buf_nxt      = buf_r >> 8;
                bcnt_nxt     = bcnt_r - 5'd8;
              end else begin
                res_stat_nxt = ended_r ? ST_END : ST_NEED;
              end
            end
          end
          default: res_stat_nxt = ST_REFUSED;
        endcase
      end
      S_EVAL: begin
        if (mode_r == M_EMIT) begin
          // pop one byte
          depth_nxt     = depth_r - FE_W'(1);
          stk_req.raddr = depth_nxt[TBL_AW-1:0];
          if (depth_nxt == '0) mode_nxt = M_DECODE;
        end else if (mode_r == M_DONE) begin
          res_stat_nxt = ST_END;
        end else if (!have_code) begin
          if (ended_r) begin
            mode_nxt     = M_DONE;
            res_stat_nxt = ST_END;
          end else begin
            res_stat_nxt = ST_NEED;
          end
        end else begin
          buf_nxt  = buf_shift;
          bcnt_nxt = bcnt_r - cw_r;
          if (mode_r == M_FIRST) begin
            fc_nxt       = code[7:0];
            prev_nxt     = code;
            mode_nxt     = M_DECODE;
            res_byte_nxt = code[7:0];
            res_stat_nxt = ST_GIVEN;
          end else if (is_clear) begin
            free_nxt = FREE_PLAIN;
            cw_nxt   = START_WIDTH;
            buf_nxt  = '0;
            bcnt_nxt = '0;
            skip_nxt = grp_r != '0;
            mode_nxt = M_CLEARED;
          end else begin
            inc_nxt = code;
            // undefined code: previous string plus its first byte
            if (code_ge_free) begin
              stk_req.we    = 1'b1;
              stk_req.waddr = '0;
              stk_req.wdata = fc_r;
              depth_nxt     = FE_W'(1);
            end else begin
              depth_nxt = '0;
            end
            if (walk_needed) begin
              dict_req.raddr = walk_start;
            end else begin
              fc_nxt = walk_start[7:0];
            end
          end
        end
      end
      S_WDATA: begin
        // one chain entry per cycle
        if (wd_room) begin
          stk_req.we    = 1'b1;
          stk_req.waddr = depth_r[TBL_AW-1:0];
          stk_req.wdata = sfx_rd;
          depth_nxt     = depth_r + FE_W'(1);
          if (wd_cont) begin
            dict_req.raddr = pfx_rd;
          end else begin
            fc_nxt = pfx_rd[7:0];
          end
        end else begin
          fc_nxt = sfx_rd;
        end
      end
      S_FIN: begin
        // first byte on the stack, new entry, width update
        stk_req.we    = 1'b1;
        stk_req.waddr = depth_r[TBL_AW-1:0];
        stk_req.wdata = fc_r;
        depth_nxt     = depth_r + FE_W'(1);
        if (can_add) begin
          dict_req.we    = 1'b1;
          dict_req.waddr = free_r[TBL_AW-1:0];
          dict_req.wpfx  = prev_r;
          dict_req.wsfx  = fc_r;
        end
        free_nxt = free_inc;
        prev_nxt = inc_r;
        if ({1'b0, free_inc} > limit) begin
          cw_nxt   = cw_r + 5'd1;
          buf_nxt  = '0;
          bcnt_nxt = '0;
          skip_nxt = grp_r != '0;
        end
        mode_nxt = M_EMIT;
      end
      S_POP: begin
        res_byte_nxt = stk_rd;
        res_stat_nxt = ST_GIVEN;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_HEADER;
      buf_r   <= '0;
      bcnt_r  <= '0;
      grp_r   <= '0;
      skip_r  <= 1'b0;
      cw_r    <= START_WIDTH;
      free_r  <= FREE_BLOCK;
      prev_r  <= '0;
      fc_r    <= '0;
      depth_r <= '0;
      hcnt_r  <= '0;
      block_r <= 1'b0;
      maxb_r  <= '0;
      ended_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      buf_r   <= buf_nxt;
      bcnt_r  <= bcnt_nxt;
      grp_r   <= grp_nxt;
      skip_r  <= skip_nxt;
      cw_r    <= cw_nxt;
      free_r  <= free_nxt;
      prev_r  <= prev_nxt;
      fc_r    <= fc_nxt;
      depth_r <= depth_nxt;
      hcnt_r  <= hcnt_nxt;
      block_r <= block_nxt;
      maxb_r  <= maxb_nxt;
      ended_r <= ended_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r  <= in_tuser;
      byte_r <= in_tdata;
    end
    inc_r      <= inc_nxt;
    res_byte_r <= res_byte_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_byte_r <= res_byte_r;
      out_stat_r <= res_stat_r;
    end
  end

endmodule
